>>> sv/dafp_pkg.sv
// Shared constants and types for the delimited ASCII frame parser.
package dafp_pkg;

  localparam int MAX_FIELD_LEN = 256;
  localparam int POS_W         = $clog2(MAX_FIELD_LEN + 1);

  localparam logic [7:0] CH_OPEN  = 8'h3A;
  localparam logic [7:0] CH_CLOSE = 8'h21;
  localparam logic [7:0] CH_SEP   = 8'h2C;

  localparam logic [2:0] EV_CMD      = 3'd0;
  localparam logic [2:0] EV_LEN      = 3'd1;
  localparam logic [2:0] EV_DATA     = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_BAD      = 3'd4;

  localparam logic [1:0] STAGE_CMD  = 2'd0;
  localparam logic [1:0] STAGE_LEN  = 2'd1;
  localparam logic [1:0] STAGE_DATA = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] pos;
  } ev_t;

endpackage

>>> sv/dafp_if.sv
// Valid/ready channel interfaces for received bytes and parser events.
interface frame_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frame_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] char_value;
  logic [7:0] char_position;

  modport source (output valid, output event_kind, output char_value,
                  output char_position, input ready);
  modport sink   (input valid, input event_kind, input char_value,
                  input char_position, output ready);
endinterface

>>> sv/dafp_front.sv
// Front end: holds the frame state, classifies each byte and pushes events.
module dafp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          push,
  output dafp_pkg::ev_t push_ev,
  input  logic          q_ready
);
  import dafp_pkg::*;

  logic             open_r, open_nxt;
  logic [1:0]       stage_r, stage_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accept;
  logic             emit;
  logic             field_full;

  assign in_ready   = q_ready;
  assign accept     = in_valid && q_ready;
  assign field_full = (pos_r >= POS_W'(MAX_FIELD_LEN));
  assign push       = accept && emit;

  always_comb begin
    open_nxt  = open_r;
    stage_nxt = stage_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    push_ev   = '0;
    if (in_byte == CH_OPEN && !open_r) begin
      open_nxt  = 1'b1;
      stage_nxt = STAGE_CMD;
      pos_nxt   = '0;
    end else if ((in_byte == CH_CLOSE && open_r) || field_full) begin
      // Closing byte or a full field ends the frame; the byte is not reported.
      emit         = 1'b1;
      push_ev.kind = (stage_r >= STAGE_DATA) ? EV_COMPLETE : EV_BAD;
      open_nxt     = 1'b0;
      stage_nxt    = STAGE_CMD;
      pos_nxt      = '0;
    end else if (in_byte == CH_SEP && open_r) begin
      if (stage_r < STAGE_DATA) begin
        stage_nxt = stage_r + 2'd1;
      end
      pos_nxt = '0;
    end else if (in_byte != CH_OPEN && open_r) begin
      emit          = 1'b1;
      push_ev.kind  = (stage_r >= STAGE_DATA) ? EV_DATA : {1'b0, stage_r};
      push_ev.value = in_byte;
      push_ev.pos   = pos_r[7:0];
      pos_nxt       = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      stage_r <= STAGE_CMD;
      pos_r   <= '0;
    end else if (accept) begin
      open_r  <= open_nxt;
      stage_r <= stage_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_close_shuts_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_ev.kind == EV_COMPLETE || push_ev.kind == EV_BAD)) |=> !open_r)
    else $error("frame still open after a close event");

  a_idle_pos_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> (pos_r == '0 && stage_r == STAGE_CMD))
    else $error("field state not cleared while no frame is open");

endmodule

>>> sv/dafp_queue.sv
// Short event queue between the classifier and the output stage.
module dafp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dafp_pkg::ev_t push_ev,
  output logic          q_ready,
  output logic          q_valid,
  output dafp_pkg::ev_t q_ev,
  input  logic          pop
);
  import dafp_pkg::*;

  ev_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_ev    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("event pushed into a full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("event popped from an empty queue");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond its depth");

endmodule

>>> sv/dafp_back.sv
// Back end: output register that presents queued events to the receiver.
module dafp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  dafp_pkg::ev_t q_ev,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output dafp_pkg::ev_t out_ev
);
  import dafp_pkg::*;

  logic valid_r;
  ev_t  ev_r;

  // Refill the register whenever it is empty or its event is being transferred.
  assign pop       = q_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_ev    = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r <= q_ev;
    end
  end

endmodule

>>> sv/delimited_ascii_frame_parser.sv
// Top level of the delimited ASCII frame parser.
//
// Bytes of frames ':command,length,data!' enter on in_ch, one per transfer.
// Each field byte leaves on out_ch as an event tagged with its field (0
// command, 1 length, 2 data) and its position in that field; a '!' or a full
// field produces frame complete (3) or bad format (4). Bytes outside a
// frame, commas, the opening ':' and a ':' inside a frame produce no event.
// An accepted event is written into the queue, then the output register,
// before it shows on out_ch. Throughput is one byte per cycle while the
// queue has room, set by the front-end classifier and the output register.
// A two-entry queue separates the classifier from the output register, so
// in_ch.ready stays high while the receiver stalls until that queue fills;
// the held event on out_ch stays stable until it is transferred.
// Synchronous reset closes any open frame, returns to the command field and
// empties the queue and output register.
module delimited_ascii_frame_parser (
  input  logic               clk,
  input  logic               rst_n,
  frame_in_if.sink           in_ch,
  frame_out_if.source        out_ch
);
  import dafp_pkg::*;

  logic push;
  ev_t  push_ev;
  logic q_ready;
  logic q_valid;
  ev_t  q_ev;
  logic pop;
  ev_t  out_ev;

  dafp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.rx_byte),
    .push     (push),
    .push_ev  (push_ev),
    .q_ready  (q_ready)
  );

  dafp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_ev    (q_ev),
    .pop     (pop)
  );

  dafp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ev      (q_ev),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_ev    (out_ev)
  );

  assign out_ch.event_kind    = out_ev.kind;
  assign out_ch.char_value    = out_ev.value;
  assign out_ch.char_position = out_ev.pos;

endmodule
